FILE: hdl/serial_eeprom_command_device_defines.svh
// ---------------------------------------------------------------------------
// Serial EEPROM command device assertion macros
// Shared assertion wrappers clocked on the block clock.
// ---------------------------------------------------------------------------
`ifndef SERIAL_EEPROM_COMMAND_DEVICE_DEFINES_SVH
`define SERIAL_EEPROM_COMMAND_DEVICE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define SED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SED_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/sed_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial EEPROM command device package
// Command codes, port bit positions and sizes for the EEPROM block.
// ---------------------------------------------------------------------------
package sed_pkg;

   localparam int SED_STORE_DEPTH = 128;

   localparam int CMD_W   = 13;
   localparam int COUNT_W = 6;
   localparam int ADDR_W  = 7;
   localparam int STAT_W  = 6;

   // Command decode on the top six bits of the shifted command
   localparam logic [CMD_W-1:0] CMD_MASK   = 13'h1f80;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 13'h0980;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 13'h0e00;
   localparam logic [CMD_W-1:0] CMD_READ   = 13'h0c00;
   localparam logic [CMD_W-1:0] CMD_LOCK   = 13'h0800;

   localparam logic [7:0]         IGNORE_BYTE  = 8'hff;
   localparam logic [7:0]         ERASED_BYTE  = 8'hff;
   localparam logic [COUNT_W-1:0] DECODE_COUNT = 6'd13;
   localparam logic [COUNT_W-1:0] MAX_COUNT    = 6'd31;

   // Control port byte bit positions
   localparam int CLK_BIT  = 4;
   localparam int DATA_BIT = 7;
   localparam int SEL_BIT  = 3;

   // Status byte bit positions
   localparam int STAT_SW_BIT  = 0;
   localparam int STAT_OUT_BIT = 4;
   localparam int STAT_ACK_BIT = 5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

endpackage

FILE: hdl/serial_eeprom_command_device.sv
`timescale 1ns / 1ps
// Serial EEPROM command device: a 128-byte EEPROM bit-banged through a control
// port and read back through a status port. Writes update the serial state at
// the accepting edge and yield no result; status reads yield one result, held
// in the result register, or in the skid stage while that one stalls. Items are
// accepted every cycle; req_stall rises only when both the result register and
// its skid stage hold results that the far side has not taken. The store is a
// 128 x 8 array with one write port and one registered read port; a read
// command issues the read at its accepting edge and the fetched byte replaces
// the output shifter from the next item on. Per-entry valid bits cleared by
// reset make unwritten bytes read as 0xFF, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// Serial EEPROM command device
// Command shifter, lock/write/read decoder, byte store and status output.
// ---------------------------------------------------------------------------
module serial_eeprom_command_device #(
   parameter int STORE_DEPTH = sed_pkg::SED_STORE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [7:0]                req_port_byte,
   input  logic                      req_test_switch,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [sed_pkg::STAT_W-1:0] rsp_status_byte
);
   import sed_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);

   // Byte store with registered read port
   logic [7:0]             store_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] store_vld_ff, store_vld_in;
   logic [7:0]             rd_data_ff;
   logic                   rd_vld_ff;
   logic                   load_pend_ff, load_pend_in;

   // Serial protocol state
   logic [CMD_W-1:0]   cmd_shift_ff, cmd_shift_in;
   logic [COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic               prev_clock_ff, prev_clock_in;
   logic               prev_select_ff, prev_select_in;
   logic               unlocked_ff, unlocked_in;
   logic               pending_write_ff, pending_write_in;
   logic [ADDR_W-1:0]  target_addr_ff, target_addr_in;
   logic [7:0]         out_shift_ff, out_shift_in;
   logic               ack_flag_ff, ack_flag_in;

   // Result register and skid stage
   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [STAT_W-1:0] skid_data_ff, skid_data_in;

   // Item decode
   logic               req_acc;
   logic               wr_item;
   logic               rd_item;
   logic               pin_clk;
   logic               pin_dat;
   logic               pin_sel;
   logic               rise;
   logic               shift_edge;
   logic               desel_edge;
   logic               commit;
   logic [CMD_W-1:0]   cmd_next;
   logic [COUNT_W-1:0] count_next;
   logic [CMD_W-1:0]   cmd_code;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [7:0]         out_shift_cur;
   logic [STAT_W-1:0]  status_new;
   logic               out_free;

   assign req_acc = req_valid && !req_stall;
   assign wr_item = req_acc && (req_op == OP_WRITE) && (req_port_byte != IGNORE_BYTE);
   assign rd_item = req_acc && (req_op == OP_READ);

   assign pin_clk = req_port_byte[CLK_BIT];
   assign pin_dat = req_port_byte[DATA_BIT];
   assign pin_sel = req_port_byte[SEL_BIT];

   assign rise       = wr_item && !prev_clock_ff && pin_clk;
   assign shift_edge = rise && pin_sel;
   assign desel_edge = rise && !pin_sel && prev_select_ff;
   assign commit     = desel_edge && pending_write_ff;

   assign cmd_next   = {cmd_shift_ff[CMD_W-2:0], pin_dat};
   assign count_next = bit_count_ff + COUNT_W'(1);
   assign cmd_code   = cmd_next & CMD_MASK;

   // Output shifter as seen by this item: a fetched byte overrides the register
   assign out_shift_cur = load_pend_ff ? (rd_vld_ff ? rd_data_ff : ERASED_BYTE)
                                       : out_shift_ff;

   // Advance the serial state for one item
   always_comb begin
      cmd_shift_in     = cmd_shift_ff;
      bit_count_in     = bit_count_ff;
      prev_clock_in    = prev_clock_ff;
      prev_select_in   = prev_select_ff;
      unlocked_in      = unlocked_ff;
      pending_write_in = pending_write_ff;
      target_addr_in   = target_addr_ff;
      ack_flag_in      = ack_flag_ff;
      store_vld_in     = store_vld_ff;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = cmd_next[ADDR_W-1:0];
      out_shift_in     = out_shift_ff;
      load_pend_in     = load_pend_ff;

      if (req_acc) begin
         out_shift_in = out_shift_cur;
         load_pend_in = 1'b0;
      end

      if (wr_item) begin
         prev_clock_in = pin_clk;
      end

      if (rise) begin
         prev_select_in = pin_sel;
      end

      if (shift_edge) begin
         cmd_shift_in = cmd_next;
         bit_count_in = count_next;
         if (count_next == DECODE_COUNT) begin
            unique case (cmd_code)
               CMD_UNLOCK: begin
                  unlocked_in = 1'b1;
               end
               CMD_WRITE: begin
                  target_addr_in = cmd_next[ADDR_W-1:0];
                  if (unlocked_ff) begin
                     pending_write_in = 1'b1;
                  end
               end
               CMD_READ: begin
                  target_addr_in = cmd_next[ADDR_W-1:0];
                  mem_rd_en      = 1'b1;
                  load_pend_in   = 1'b1;
               end
               CMD_LOCK: begin
                  unlocked_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (count_next > MAX_COUNT) begin
            bit_count_in = '0;
            cmd_shift_in = '0;
         end
      end else if (desel_edge) begin
         if (pending_write_ff) begin
            store_vld_in[target_addr_ff[IDX_W-1:0]] = 1'b1;
            ack_flag_in      = 1'b1;
            pending_write_in = 1'b0;
         end
         bit_count_in = '0;
         cmd_shift_in = '0;
      end

      // Status read: shift out one bit and drop the acknowledge
      if (rd_item) begin
         out_shift_in = {out_shift_cur[6:0], 1'b0};
         ack_flag_in  = 1'b0;
      end
   end

   // Build the status byte for a read item
   always_comb begin
      status_new               = '0;
      status_new[STAT_SW_BIT]  = req_test_switch;
      status_new[STAT_OUT_BIT] = out_shift_cur[7];
      status_new[STAT_ACK_BIT] = ack_flag_ff;
   end

   // Steer results through the result register and skid stage
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (rd_item) begin
            out_valid_in = 1'b1;
            out_data_in  = status_new;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (rd_item) begin
         skid_valid_in = 1'b1;
         skid_data_in  = status_new;
      end
   end

   // Control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_shift_ff     <= '0;
         bit_count_ff     <= '0;
         prev_clock_ff    <= 1'b0;
         prev_select_ff   <= 1'b0;
         unlocked_ff      <= 1'b0;
         pending_write_ff <= 1'b0;
         target_addr_ff   <= '0;
         out_shift_ff     <= '0;
         ack_flag_ff      <= 1'b0;
         store_vld_ff     <= '0;
         load_pend_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         cmd_shift_ff     <= cmd_shift_in;
         bit_count_ff     <= bit_count_in;
         prev_clock_ff    <= prev_clock_in;
         prev_select_ff   <= prev_select_in;
         unlocked_ff      <= unlocked_in;
         pending_write_ff <= pending_write_in;
         target_addr_ff   <= target_addr_in;
         out_shift_ff     <= out_shift_in;
         ack_flag_ff      <= ack_flag_in;
         store_vld_ff     <= store_vld_in;
         load_pend_ff     <= load_pend_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Store write port
   always_ff @(posedge clock) begin
      if (commit) begin
         store_mem[target_addr_ff[IDX_W-1:0]] <= cmd_shift_ff[7:0];
      end
   end

   // Store read port, registered
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= store_mem[mem_rd_addr[IDX_W-1:0]];
         rd_vld_ff  <= store_vld_ff[mem_rd_addr[IDX_W-1:0]];
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_status_byte = out_data_ff;

   // Checks
`include "serial_eeprom_command_device_defines.svh"

   `SED_ASSERT(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid holds item with empty output")
   `SED_ASSERT(a_commit_acks, commit |=> (ack_flag_ff && !pending_write_ff), "commit did not ack")
   `SED_ASSERT(a_count_range, bit_count_ff <= MAX_COUNT, "bit count out of range")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial EEPROM command device testbench
// Bit-bangs command frames (unlock, lock, write, read, unknown, overlong and
// cut-short) through the control port, mixed with status reads and port
// noise. A behavioral image of the EEPROM tracks every accepted item and
// predicts each status byte, which is checked in order against the results.
// Traffic runs with no idling, with sender gaps, with result stalls, with
// both, and with one long result hold-off that backs up the request side.
// ---------------------------------------------------------------------------
module tb;
   import sed_pkg::*;

   localparam int CLK_HALF_NS  = 10;
   localparam int RESET_CYCLES = 2;
   localparam int LONG_HOLD    = 150;
   localparam int TAIL_CYCLES  = 8;
   localparam int WATCHDOG_NS  = 5_000_000;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic              req_op          = OP_WRITE;
   logic [7:0]        req_port_byte   = 8'h00;
   logic              req_test_switch = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   logic [STAT_W-1:0] rsp_status_byte;

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int unsigned hold_grants   = 0;
   int unsigned holds_done    = 0;
   int unsigned items_sent    = 0;
   int unsigned mismatches    = 0;

   // Behavioral image of the EEPROM and its serial front end
   logic [7:0]         mem_image [SED_STORE_DEPTH];
   logic [CMD_W-1:0]   cmd_bits    = '0;
   logic [COUNT_W-1:0] bit_cnt     = '0;
   logic               pin_clk_lvl = 1'b0;
   logic               last_sel    = 1'b0;
   logic               is_unlocked = 1'b0;
   logic               write_armed = 1'b0;
   logic [ADDR_W-1:0]  cmd_addr    = '0;
   logic [7:0]         dout_shift  = 8'h00;
   logic               ack_seen    = 1'b0;
   logic [STAT_W-1:0]  status_q [$];

   serial_eeprom_command_device i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_port_byte   (req_port_byte),
      .req_test_switch (req_test_switch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status_byte (rsp_status_byte)
   );

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   // Advance the EEPROM image by one accepted item; queue the status a read returns
   task automatic update_eeprom_image(input logic op, input logic [7:0] pb, input logic sw);
      logic              clk_lvl;
      logic              sel_lvl;
      logic [STAT_W-1:0] status;
      clk_lvl = pb[CLK_BIT];
      sel_lvl = pb[SEL_BIT];
      status  = '0;
      if (op == OP_READ) begin
         status[STAT_OUT_BIT] = dout_shift[7];
         status[STAT_ACK_BIT] = ack_seen;
         status[STAT_SW_BIT]  = sw;
         status_q.push_back(status);
         dout_shift = {dout_shift[6:0], 1'b0};
         ack_seen   = 1'b0;
         return;
      end
      if (pb == IGNORE_BYTE) return;
      if (!pin_clk_lvl && clk_lvl) begin
         if (sel_lvl) begin
            cmd_bits = {cmd_bits[CMD_W-2:0], pb[DATA_BIT]};
            bit_cnt  = bit_cnt + 1'b1;
            // decode once the full command has arrived
            if (bit_cnt == DECODE_COUNT) begin
               case (cmd_bits & CMD_MASK)
                  CMD_UNLOCK: begin
                     is_unlocked = 1'b1;
                  end
                  CMD_WRITE: begin
                     cmd_addr = cmd_bits[ADDR_W-1:0];
                     if (is_unlocked) write_armed = 1'b1;
                  end
                  CMD_READ: begin
                     cmd_addr   = cmd_bits[ADDR_W-1:0];
                     dout_shift = mem_image[cmd_bits[ADDR_W-1:0]];
                  end
                  CMD_LOCK: begin
                     is_unlocked = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            if (bit_cnt > MAX_COUNT) begin
               bit_cnt  = '0;
               cmd_bits = '0;
            end
         end else if (last_sel) begin
            // deselect edge: commit an armed store, then drop the frame
            if (write_armed) begin
               mem_image[cmd_addr] = cmd_bits[7:0];
               ack_seen    = 1'b1;
               write_armed = 1'b0;
            end
            bit_cnt  = '0;
            cmd_bits = '0;
         end
         last_sel = sel_lvl;
      end
      pin_clk_lvl = clk_lvl;
   endtask

   // Offer one item, hold it until accepted, then track it
   task automatic send_item(input logic op, input logic [7:0] pb, input logic sw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_port_byte   <= pb;
      req_test_switch <= sw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_eeprom_image(op, pb, sw);
      if (!(op == OP_WRITE && pb == IGNORE_BYTE)) items_sent++;
   endtask

   // Control byte with the given clock, data and select; other bits random
   function automatic logic [7:0] port_bits(input logic dat, input logic clk_lvl,
                                            input logic sel_lvl);
      logic [7:0] pb;
      pb           = 8'($urandom);
      pb[DATA_BIT] = dat;
      pb[CLK_BIT]  = clk_lvl;
      pb[SEL_BIT]  = sel_lvl;
      if (pb == IGNORE_BYTE) pb[0] = 1'b0;
      return pb;
   endfunction

   // One serial clock: low, then high
   task automatic clock_in(input logic dat, input logic sel_lvl);
      send_item(OP_WRITE, port_bits(dat, 1'b0, sel_lvl), 1'($urandom));
      send_item(OP_WRITE, port_bits(dat, 1'b1, sel_lvl), 1'($urandom));
   endtask

   // Deselect, shift n bits MSB first with select high, deselect again
   task automatic run_frame(input logic [63:0] bits_in, input int n);
      clock_in(1'($urandom), 1'b0);
      for (int i = n - 1; i >= 0; i--) clock_in(bits_in[i], 1'b1);
      clock_in(1'($urandom), 1'b0);
   endtask

   task automatic read_status(input int n);
      repeat (n) send_item(OP_READ, 8'($urandom), 1'($urandom));
   endtask

   // Favor a few hot bytes and the ends of the store so reads find written data
   function automatic logic [ADDR_W-1:0] pick_addr();
      case ($urandom_range(3))
         0:       return ADDR_W'($urandom_range(7));
         1:       return {ADDR_W{1'($urandom)}};
         default: return ADDR_W'($urandom);
      endcase
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0) @(posedge clock);
   endtask

   // One random transaction: mostly well-formed frames, some broken ones and noise
   task automatic random_transaction();
      int unsigned       pick;
      logic [ADDR_W-1:0] addr;
      logic [CMD_W-1:0]  word;
      pick = $urandom_range(99);
      addr = pick_addr();
      if (pick < 30) begin
         run_frame(64'({CMD_WRITE | CMD_W'(addr), 8'($urandom)}), CMD_W + 8);
         read_status($urandom_range(1, 2));
      end else if (pick < 55) begin
         run_frame(64'(CMD_READ | CMD_W'(addr)), CMD_W);
         read_status($urandom_range(1, 9));
      end else if (pick < 67) begin
         run_frame(64'(CMD_UNLOCK | CMD_W'($urandom_range(127))), CMD_W);
      end else if (pick < 73) begin
         run_frame(64'(CMD_LOCK | CMD_W'($urandom_range(127))), CMD_W);
      end else if (pick < 80) begin
         word = CMD_W'($urandom);
         if ((word & CMD_MASK) inside {CMD_UNLOCK, CMD_WRITE, CMD_READ, CMD_LOCK})
            word[CMD_W-1] = 1'b1;
         run_frame(64'(word), CMD_W);
         read_status(1);
      end else if (pick < 85) begin
         run_frame({$urandom, $urandom}, $urandom_range(32, 40));
         read_status(1);
      end else if (pick < 92) begin
         run_frame({$urandom, $urandom}, $urandom_range(1, 12));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(1))
               send_item(OP_READ, 8'($urandom), 1'($urandom));
            else
               send_item(OP_WRITE, ($urandom_range(7) == 0) ? IGNORE_BYTE : 8'($urandom),
                         1'($urandom));
         end
      end
   endtask

   // Single-item edge cases on the control and status ports
   task automatic test_port_edges();
      send_item(OP_READ, 8'h00, 1'b0);
      send_item(OP_READ, 8'hff, 1'b1);
      // all-ones byte is dropped, so the clock level stays low across it
      send_item(OP_WRITE, 8'h00, 1'b1);
      send_item(OP_WRITE, IGNORE_BYTE, 1'b0);
      send_item(OP_WRITE, 8'hf7, 1'b0);   // rising edge, select low, was low
      send_item(OP_WRITE, 8'hf7, 1'b1);   // clock held high: no edge
      send_item(OP_WRITE, 8'h08, 1'b0);
      send_item(OP_WRITE, 8'hb8, 1'b0);   // shift a one
      send_item(OP_WRITE, 8'h48, 1'b0);
      send_item(OP_WRITE, 8'h5c, 1'b0);   // shift a zero
      send_item(OP_WRITE, 8'h87, 1'b0);
      send_item(OP_WRITE, 8'h10, 1'b0);   // deselect edge drops the partial command
      send_item(OP_READ, 8'h5a, 1'b1);
      send_item(OP_READ, 8'ha5, 1'b0);
      drain_results();
   endtask

   // Each command, locked writes, unknown codes and an overlong frame
   task automatic test_command_decode();
      run_frame(64'(CMD_LOCK | CMD_W'($urandom_range(127))), CMD_W);
      run_frame(64'({CMD_WRITE | CMD_W'({ADDR_W{1'b1}}), 8'($urandom)}), CMD_W + 8);
      read_status(1);
      run_frame(64'(CMD_READ | CMD_W'({ADDR_W{1'b1}})), CMD_W);
      read_status(9);
      run_frame(64'(CMD_UNLOCK | CMD_W'($urandom_range(127))), CMD_W);
      run_frame(64'({CMD_WRITE, 8'($urandom)}), CMD_W + 8);
      read_status(2);
      run_frame(64'(CMD_READ), CMD_W);
      read_status(9);
      run_frame(64'({CMD_WRITE | CMD_W'({ADDR_W{1'b1}}), 8'($urandom)}), CMD_W + 8);
      run_frame(64'(CMD_READ | CMD_W'({ADDR_W{1'b1}})), CMD_W);
      read_status(9);
      run_frame(64'(CMD_MASK | CMD_W'($urandom_range(127))), CMD_W);
      run_frame({$urandom, $urandom}, 33);
      read_status(2);
      drain_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int hold_pct,
                                      input int unsigned n_items);
      int unsigned goal;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      goal          = items_sent + n_items;
      while (items_sent < goal) random_transaction();
      drain_results();
   endtask

   // Hold results off for a long stretch while reads keep coming
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_frame(64'(CMD_READ | CMD_W'(pick_addr())), CMD_W);
      hold_grants++;
      read_status(40);
      drain_results();
   endtask

   // Drive result stalls: random per cycle, or a long counted hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_grants) begin
            repeat (LONG_HOLD) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            holds_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted result against the oldest predicted status
   always @(posedge clock) begin
      logic [STAT_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_q.size() == 0) begin
            $error("status_byte: no result expected, actual %02h", rsp_status_byte);
            mismatches++;
         end else begin
            want = status_q.pop_front();
            if (rsp_status_byte !== want) begin
               $error("status_byte mismatch: expected %02h, actual %02h", want,
                      rsp_status_byte);
               mismatches++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SED_STORE_DEPTH; i++) mem_image[i] = ERASED_BYTE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_port_edges();
      test_command_decode();
      test_random_traffic(0, 0, 130);
      test_random_traffic(81, 0, 130);
      test_random_traffic(0, 81, 130);
      test_random_traffic(10, 10, 130);
      test_result_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && status_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(WATCHDOG_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
